// File: hdl/baro_pkg.sv
// Shared types and constants for the barometer compensation pipeline.
// No dependencies; every other file in hdl/ imports this package.
package baro_pkg;

	localparam int RAW_W     = 24;   // raw conversion codes
	localparam int SCALE_W   = 23;   // oversampling scale factors
	localparam int OUT_W     = 24;   // result fields
	localparam int CFG_W     = 48;   // widest config register
	localparam int CFG_IDX_W = 3;

	localparam int SMALL_W   = 48;   // front-end coefficient products
	localparam int WIDE_W    = 122;  // signed polynomial accumulator
	localparam int MULB_W    = 25;   // narrow multiplier operand
	localparam int CHUNK_W   = 32;   // wide operand slice per multiplier
	localparam int PP_W      = CHUNK_W + 1 + MULB_W;
	localparam int PPT_W     = (WIDE_W - 3 * CHUNK_W) + MULB_W;

	localparam int DIV_W     = 120;  // dividend magnitude
	localparam int DEN_W     = 92;   // kT * kP^3
	localparam int QUO_W     = 25;   // quotient bits resolved, one per stage
	localparam int TQ_W      = QUO_W + 2;

	localparam int PRESS_SH  = 6;    // 1/64 Pa
	localparam int TEMP_SH   = 8;    // 1/256 degC
	localparam int C0_SH     = 7;    // c0/2 in 1/256 degC

	localparam int FRONT_LAT = 3;
	localparam int POLY_LAT  = 8;
	localparam int PIPE_D    = FRONT_LAT + POLY_LAT + QUO_W + 1;

	localparam logic [SCALE_W-1:0] TEMP_SCALE_RST  = SCALE_W'(516096);
	localparam logic [SCALE_W-1:0] PRESS_SCALE_RST = SCALE_W'(1040384);

	localparam logic signed [TQ_W-1:0] TQ_HI = TQ_W'((2 ** (OUT_W - 1)) - 1);
	localparam logic signed [TQ_W-1:0] TQ_LO = -TQ_HI - TQ_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP_COEFS  = 3'd0,
		CFG_PRESS_LIN   = 3'd1,
		CFG_PRESS_CROSS = 3'd2,
		CFG_PRESS_HIGH  = 3'd3,
		CFG_TEMP_SCALE  = 3'd4,
		CFG_PRESS_SCALE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [11:0] c0;
		logic signed [11:0] c1;
		logic signed [19:0] c00;
		logic signed [19:0] c10;
		logic signed [15:0] c01;
		logic signed [15:0] c11;
		logic signed [15:0] c20;
		logic signed [15:0] c21;
		logic signed [15:0] c30;
		logic [SCALE_W-1:0] kt;
		logic [SCALE_W-1:0] kp;
	} coef_t;

	typedef struct packed {
		logic [OUT_W-1:0] temperature;
		logic [OUT_W-1:0] pressure;
		logic             clamped;
	} result_t;

endpackage

// File: hdl/baro_mac.sv
// Two-stage wide multiply-accumulate: y = a * b + c, modulo 2^WIDE_W.
// Depends on baro_pkg.
module baro_mac (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [baro_pkg::WIDE_W-1:0] a,
	input  logic signed [baro_pkg::MULB_W-1:0] b,
	input  logic signed [baro_pkg::WIDE_W-1:0] c,
	output logic signed [baro_pkg::WIDE_W-1:0] y
);
	import baro_pkg::*;

	logic signed [PP_W-1:0]   pp0_s1, pp1_s1, pp2_s1;
	logic signed [PPT_W-1:0]  pp3_s1;
	logic signed [WIDE_W-1:0] c_s1;
	logic signed [WIDE_W-1:0] sum;

	// low slices are unsigned, top slice carries the sign
	always_ff @(posedge clk) begin
		if (en) begin
			pp0_s1 <= $signed({1'b0, a[CHUNK_W-1:0]}) * b;
			pp1_s1 <= $signed({1'b0, a[2*CHUNK_W-1:CHUNK_W]}) * b;
			pp2_s1 <= $signed({1'b0, a[3*CHUNK_W-1:2*CHUNK_W]}) * b;
			pp3_s1 <= $signed(a[WIDE_W-1:3*CHUNK_W]) * b;
			c_s1   <= c;
		end
	end

	always_comb begin
		sum = c_s1 + WIDE_W'(pp0_s1)
			+ (WIDE_W'(pp1_s1) <<< CHUNK_W)
			+ (WIDE_W'(pp2_s1) <<< (2 * CHUNK_W))
			+ (WIDE_W'(pp3_s1) <<< (3 * CHUNK_W));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= sum;
		end
	end

endmodule

// File: hdl/baro_div.sv
// Pipelined restoring divider: one quotient bit per stage, plus overflow detect.
// Depends on baro_pkg.
module baro_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [baro_pkg::DIV_W-1:0]  num,
	input  logic [baro_pkg::DEN_W-1:0]  den,
	input  logic                        side_in,
	output logic [baro_pkg::QUO_W-1:0]  quo,
	output logic                        rem_nz,
	output logic                        ovf,
	output logic                        side_out
);
	import baro_pkg::*;

	logic [DIV_W-1:0] rem_s  [0:QUO_W];
	logic [DEN_W-1:0] d_s    [0:QUO_W-1];
	logic [QUO_W-1:0] q_s    [0:QUO_W];
	logic             ovf_s  [0:QUO_W];
	logic             side_s [0:QUO_W];

	// quotient at or above 2^QUO_W is flagged up front
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			d_s[0]    <= den;
			q_s[0]    <= '0;
			ovf_s[0]  <= num >= (DIV_W'(den) << QUO_W);
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		localparam int Bit = QUO_W - k;
		logic [DIV_W-1:0] trial;
		logic             ge;

		assign trial = DIV_W'(d_s[k-1]) << Bit;
		assign ge    = rem_s[k-1] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (rem_s[k-1] - trial) : rem_s[k-1];
				q_s[k]    <= q_s[k-1] | (QUO_W'(ge) << Bit);
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end

		if (k < QUO_W) begin : g_dpass
			always_ff @(posedge clk) begin
				if (en) begin
					d_s[k] <= d_s[k-1];
				end
			end
		end
	end

	assign quo      = q_s[QUO_W];
	assign rem_nz   = |rem_s[QUO_W];
	assign ovf      = ovf_s[QUO_W];
	assign side_out = side_s[QUO_W];

endmodule

// File: hdl/baro_front.sv
// Front end: input register, coefficient products, Horner coefficients and
// the temperature dividend magnitude. Depends on baro_pkg.
module baro_front (
	input  logic                               clk,
	input  logic                               en,
	input  baro_pkg::coef_t                    coef,
	input  logic signed [baro_pkg::RAW_W-1:0]  raw_t,
	input  logic signed [baro_pkg::RAW_W-1:0]  raw_p,
	output logic signed [baro_pkg::WIDE_W-1:0] a3_s3,
	output logic signed [baro_pkg::WIDE_W-1:0] a2_s3,
	output logic signed [baro_pkg::WIDE_W-1:0] a1_s3,
	output logic signed [baro_pkg::WIDE_W-1:0] a0_s3,
	output logic signed [baro_pkg::WIDE_W-1:0] ktkp_s3,
	output logic signed [baro_pkg::RAW_W-1:0]  p_s3,
	output logic [baro_pkg::DIV_W-1:0]         tmag_s3,
	output logic                               tneg_s3
);
	import baro_pkg::*;

	logic signed [RAW_W-1:0]   t_s1, p_s1, p_s2;
	logic signed [SCALE_W:0]   kts, kps;
	logic signed [SMALL_W-1:0] ktc30_s2, c20kt_s2, c21t_s2, c10kt_s2, c11t_s2;
	logic signed [SMALL_W-1:0] c00kt_s2, c01t_s2, c1t_s2, ktkp_s2;
	logic [SMALL_W-1:0]        c1t_abs;

	assign kts = $signed({1'b0, coef.kt});
	assign kps = $signed({1'b0, coef.kp});

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= raw_t;
			p_s1 <= raw_p;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ktc30_s2 <= kts * $signed(coef.c30);
			c20kt_s2 <= kts * $signed(coef.c20);
			c21t_s2  <= t_s1 * $signed(coef.c21);
			c10kt_s2 <= kts * $signed(coef.c10);
			c11t_s2  <= t_s1 * $signed(coef.c11);
			c00kt_s2 <= kts * $signed(coef.c00);
			c01t_s2  <= t_s1 * $signed(coef.c01);
			c1t_s2   <= t_s1 * $signed(coef.c1);
			ktkp_s2  <= kts * kps;
			p_s2     <= p_s1;
		end
	end

	assign c1t_abs = c1t_s2[SMALL_W-1] ? -c1t_s2 : c1t_s2;

	// every pressure term is pre-scaled by 64 so the final quotient is in 1/64 Pa
	always_ff @(posedge clk) begin
		if (en) begin
			a3_s3   <= WIDE_W'(ktc30_s2) <<< PRESS_SH;
			a2_s3   <= (WIDE_W'(c20kt_s2) + WIDE_W'(c21t_s2)) <<< PRESS_SH;
			a1_s3   <= (WIDE_W'(c10kt_s2) + WIDE_W'(c11t_s2)) <<< PRESS_SH;
			a0_s3   <= (WIDE_W'(c00kt_s2) + WIDE_W'(c01t_s2)) <<< PRESS_SH;
			ktkp_s3 <= WIDE_W'(ktkp_s2);
			p_s3    <= p_s2;
			tmag_s3 <= DIV_W'(c1t_abs) << TEMP_SH;
			tneg_s3 <= c1t_s2[SMALL_W-1];
		end
	end

endmodule

// File: hdl/baro_poly.sv
// Pressure polynomial in Horner form over raw pressure, and the common
// denominator kT*kP^3, in four rounds of multiply-accumulate. Depends on baro_pkg, baro_mac.
module baro_poly (
	input  logic                               clk,
	input  logic                               en,
	input  logic [baro_pkg::SCALE_W-1:0]       kp,
	input  logic signed [baro_pkg::WIDE_W-1:0] a3,
	input  logic signed [baro_pkg::WIDE_W-1:0] a2,
	input  logic signed [baro_pkg::WIDE_W-1:0] a1,
	input  logic signed [baro_pkg::WIDE_W-1:0] a0,
	input  logic signed [baro_pkg::WIDE_W-1:0] ktkp,
	input  logic signed [baro_pkg::RAW_W-1:0]  p,
	output logic signed [baro_pkg::WIDE_W-1:0] s0_s11,
	output logic signed [baro_pkg::WIDE_W-1:0] den_s11
);
	import baro_pkg::*;

	logic signed [MULB_W-1:0] kpb;
	logic signed [WIDE_W-1:0] y2_s5, z1_s5, w1_s5, d1_s5;
	logic signed [WIDE_W-1:0] s2_s7, z2_s7, w2_s7, d2_s7;
	logic signed [WIDE_W-1:0] s1_s9, w3_s9;
	logic signed [WIDE_W-1:0] a3_s4, a3_s5;
	logic signed [WIDE_W-1:0] den_s8, den_s9, den_s10;
	logic signed [RAW_W-1:0]  p_s4, p_s5, p_s6, p_s7, p_s8, p_s9;
	logic signed [MULB_W-1:0] pb_s5, pb_s7, pb_s9;
	logic signed [WIDE_W-1:0] zero;

	assign kpb   = $signed({2'b00, kp});
	assign zero  = '0;
	assign pb_s5 = $signed({p_s5[RAW_W-1], p_s5});
	assign pb_s7 = $signed({p_s7[RAW_W-1], p_s7});
	assign pb_s9 = $signed({p_s9[RAW_W-1], p_s9});

	always_ff @(posedge clk) begin
		if (en) begin
			a3_s4   <= a3;
			a3_s5   <= a3_s4;
			p_s4    <= p;
			p_s5    <= p_s4;
			p_s6    <= p_s5;
			p_s7    <= p_s6;
			p_s8    <= p_s7;
			p_s9    <= p_s8;
			den_s8  <= d2_s7;
			den_s9  <= den_s8;
			den_s10 <= den_s9;
			den_s11 <= den_s10;
		end
	end

	// round 1: first powers of kP
	baro_mac u_y2 (.clk(clk), .en(en), .a(a2),   .b(kpb), .c(zero), .y(y2_s5));
	baro_mac u_z1 (.clk(clk), .en(en), .a(a1),   .b(kpb), .c(zero), .y(z1_s5));
	baro_mac u_w1 (.clk(clk), .en(en), .a(a0),   .b(kpb), .c(zero), .y(w1_s5));
	baro_mac u_d1 (.clk(clk), .en(en), .a(ktkp), .b(kpb), .c(zero), .y(d1_s5));

	// round 2: first Horner step
	baro_mac u_s2 (.clk(clk), .en(en), .a(a3_s5), .b(pb_s5), .c(y2_s5), .y(s2_s7));
	baro_mac u_z2 (.clk(clk), .en(en), .a(z1_s5), .b(kpb),   .c(zero),  .y(z2_s7));
	baro_mac u_w2 (.clk(clk), .en(en), .a(w1_s5), .b(kpb),   .c(zero),  .y(w2_s7));
	baro_mac u_d2 (.clk(clk), .en(en), .a(d1_s5), .b(kpb),   .c(zero),  .y(d2_s7));

	// round 3
	baro_mac u_s1 (.clk(clk), .en(en), .a(s2_s7), .b(pb_s7), .c(z2_s7), .y(s1_s9));
	baro_mac u_w3 (.clk(clk), .en(en), .a(w2_s7), .b(kpb),   .c(zero),  .y(w3_s9));

	// round 4
	baro_mac u_s0 (.clk(clk), .en(en), .a(s1_s9), .b(pb_s9), .c(w3_s9), .y(s0_s11));

endmodule

// File: hdl/barometer_compensation.sv
// Barometer compensation top level: config registers, pipeline, dividers, output skid.
// Accepts one beat per cycle sustained unless both output skid slots are full (in_stall).
// Depth is set by the 3-stage front end, four multiply-accumulate rounds of the
// pressure polynomial and the 26-stage restoring divider (overflow check, then one
// quotient bit per stage). Reset clears all pipeline valids and empties the output buffer; scales
// return to their default values and coefficients to zero. Depends on baro_pkg and all baro_* modules.
module barometer_compensation (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [baro_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [baro_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [baro_pkg::RAW_W-1:0]     temp_code,
	input  logic signed [baro_pkg::RAW_W-1:0]     press_code,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [baro_pkg::OUT_W-1:0]     temperature_out,
	output logic [baro_pkg::OUT_W-1:0]            pressure_out,
	output logic                                  clamped
);
	import baro_pkg::*;

	logic [23:0]          temp_coefs_q;
	logic [39:0]          press_lin_coefs_q;
	logic [47:0]          press_cross_coefs_q;
	logic [31:0]          press_high_coefs_q;
	logic [SCALE_W-1:0]   temp_scale_q, press_scale_q;
	coef_t                coef;

	logic                 adv, push, pop;
	logic [PIPE_D-1:0]    vld_s;
	logic [1:0]           skid_cnt_q;
	result_t              buf0_q, buf1_q, res;

	logic signed [WIDE_W-1:0] a3_s3, a2_s3, a1_s3, a0_s3, ktkp_s3;
	logic signed [RAW_W-1:0]  p_s3;
	logic [DIV_W-1:0]         tmag_s3;
	logic                     tneg_s3;
	logic signed [WIDE_W-1:0] s0_s11, den_s11;
	logic [DIV_W-1:0]         tmag_dly [0:POLY_LAT-1];
	logic                     tneg_dly [0:POLY_LAT-1];

	logic [QUO_W-1:0]         tquo, pquo;
	logic                     trnz, tovf, tneg, povf, pneg;
	logic signed [TQ_W-1:0]   qe, quo, tq;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coefs_q        <= '0;
			press_lin_coefs_q   <= '0;
			press_cross_coefs_q <= '0;
			press_high_coefs_q  <= '0;
			temp_scale_q        <= TEMP_SCALE_RST;
			press_scale_q       <= PRESS_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_TEMP_COEFS:  temp_coefs_q        <= cfg_data[23:0];
				CFG_PRESS_LIN:   press_lin_coefs_q   <= cfg_data[39:0];
				CFG_PRESS_CROSS: press_cross_coefs_q <= cfg_data[47:0];
				CFG_PRESS_HIGH:  press_high_coefs_q  <= cfg_data[31:0];
				CFG_TEMP_SCALE:  temp_scale_q        <= cfg_data[SCALE_W-1:0];
				CFG_PRESS_SCALE: press_scale_q       <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.c0  = $signed(temp_coefs_q[23:12]);
		coef.c1  = $signed(temp_coefs_q[11:0]);
		coef.c00 = $signed(press_lin_coefs_q[39:20]);
		coef.c10 = $signed(press_lin_coefs_q[19:0]);
		coef.c01 = $signed(press_cross_coefs_q[47:32]);
		coef.c11 = $signed(press_cross_coefs_q[31:16]);
		coef.c20 = $signed(press_cross_coefs_q[15:0]);
		coef.c21 = $signed(press_high_coefs_q[31:16]);
		coef.c30 = $signed(press_high_coefs_q[15:0]);
		// zero scale behaves as one
		coef.kt  = (temp_scale_q == '0) ? SCALE_W'(1) : temp_scale_q;
		coef.kp  = (press_scale_q == '0) ? SCALE_W'(1) : press_scale_q;
	end

	// ---------------- pipeline control ----------------
	// whole pipe moves together; it freezes only when both skid slots are taken
	assign adv      = (skid_cnt_q != 2'd2);
	assign in_stall = !adv;
	assign push     = vld_s[PIPE_D-1] && adv;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_D-2:0], in_valid};
		end
	end

	// ---------------- datapath ----------------
	baro_front u_front (
		.clk     (clk),
		.en      (adv),
		.coef    (coef),
		.raw_t   (temp_code),
		.raw_p   (press_code),
		.a3_s3   (a3_s3),
		.a2_s3   (a2_s3),
		.a1_s3   (a1_s3),
		.a0_s3   (a0_s3),
		.ktkp_s3 (ktkp_s3),
		.p_s3    (p_s3),
		.tmag_s3 (tmag_s3),
		.tneg_s3 (tneg_s3)
	);

	baro_poly u_poly (
		.clk     (clk),
		.en      (adv),
		.kp      (coef.kp),
		.a3      (a3_s3),
		.a2      (a2_s3),
		.a1      (a1_s3),
		.a0      (a0_s3),
		.ktkp    (ktkp_s3),
		.p       (p_s3),
		.s0_s11  (s0_s11),
		.den_s11 (den_s11)
	);

	// temperature dividend waits for the pressure polynomial
	always_ff @(posedge clk) begin
		if (adv) begin
			tmag_dly[0] <= tmag_s3;
			tneg_dly[0] <= tneg_s3;
			for (int i = 1; i < POLY_LAT; i++) begin
				tmag_dly[i] <= tmag_dly[i-1];
				tneg_dly[i] <= tneg_dly[i-1];
			end
		end
	end

	baro_div u_tdiv (
		.clk      (clk),
		.en       (adv),
		.num      (tmag_dly[POLY_LAT-1]),
		.den      (DEN_W'(coef.kt)),
		.side_in  (tneg_dly[POLY_LAT-1]),
		.quo      (tquo),
		.rem_nz   (trnz),
		.ovf      (tovf),
		.side_out (tneg)
	);

	baro_div u_pdiv (
		.clk      (clk),
		.en       (adv),
		.num      (s0_s11[DIV_W-1:0]),
		.den      (den_s11[DEN_W-1:0]),
		.side_in  (s0_s11[WIDE_W-1]),
		.quo      (pquo),
		.rem_nz   (),
		.ovf      (povf),
		.side_out (pneg)
	);

	// ---------------- floor, offset and saturate ----------------
	always_comb begin
		qe  = $signed({2'b00, tquo});
		// floor of a negative ratio rounds the magnitude up
		quo = tneg ? -(qe + TQ_W'(trnz)) : qe;
		tq  = quo + (TQ_W'(coef.c0) <<< C0_SH);
		res = '0;

		if (tovf) begin
			res.temperature = tneg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
			res.clamped     = 1'b1;
		end else if (tq > TQ_HI) begin
			res.temperature = {1'b0, {(OUT_W-1){1'b1}}};
			res.clamped     = 1'b1;
		end else if (tq < TQ_LO) begin
			res.temperature = {1'b1, {(OUT_W-1){1'b0}}};
			res.clamped     = 1'b1;
		end else begin
			res.temperature = tq[OUT_W-1:0];
		end

		if (pneg) begin
			res.pressure = '0;
			res.clamped  = 1'b1;
		end else if (povf || pquo[QUO_W-1]) begin
			res.pressure = '1;
			res.clamped  = 1'b1;
		end else begin
			res.pressure = pquo[OUT_W-1:0];
		end
	end

	// ---------------- output skid, two beats ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_cnt_q <= '0;
		end else if (push && !pop) begin
			skid_cnt_q <= skid_cnt_q + 2'd1;
		end else if (pop && !push) begin
			skid_cnt_q <= skid_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_cnt_q == 2'd2) begin
			buf0_q <= buf1_q;
		end else if (push && (skid_cnt_q == 2'd0 || (skid_cnt_q == 2'd1 && pop))) begin
			buf0_q <= res;
		end
		if (push && skid_cnt_q == 2'd1 && !pop) begin
			buf1_q <= res;
		end
	end

	assign out_valid       = (skid_cnt_q != 2'd0);
	assign temperature_out = $signed(buf0_q.temperature);
	assign pressure_out    = buf0_q.pressure;
	assign clamped         = buf0_q.clamped;

	// ---------------- checks ----------------
	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline valids moved while frozen");

	a_stall_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_skid_bound: assert property (@(posedge clk) disable iff (!arst_n)
		skid_cnt_q != 2'd3)
		else $error("output skid overfilled");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for barometer_compensation: directed table, then randomized phases.
// Predicts each result with exact wide integer arithmetic; needs baro_pkg and the RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import baro_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam int DRAIN_CYC = PIPE_D + 8;
	localparam int RAND_PHASES = 9;
	localparam int BEATS_PER_PHASE = 190;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [RAW_W-1:0] temp_code = '0;
	logic signed [RAW_W-1:0] press_code = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] temperature_out;
	logic [OUT_W-1:0] pressure_out;
	logic clamped;

	barometer_compensation dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copies of the config registers
	logic [23:0] sh_temp_coefs = '0;
	logic [39:0] sh_press_lin = '0;
	logic [47:0] sh_press_cross = '0;
	logic [31:0] sh_press_high = '0;
	logic [SCALE_W-1:0] sh_kt = TEMP_SCALE_RST;
	logic [SCALE_W-1:0] sh_kp = PRESS_SCALE_RST;

	result_t pending[$];
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int clamp_seen = 0;
	int press_mid = 0;

	function automatic result_t compensate(logic signed [RAW_W-1:0] t_raw,
			logic signed [RAW_W-1:0] p_raw);
		longint kt, kp, c0, c1, t, tn, tq;
		logic signed [191:0] a0, a1, a2, a3, s, den, q, p, kpw, ktw, tw;
		result_t r;
		kt = (sh_kt == 0) ? 1 : longint'(sh_kt);
		kp = (sh_kp == 0) ? 1 : longint'(sh_kp);
		c0 = longint'($signed(sh_temp_coefs[23:12]));
		c1 = longint'($signed(sh_temp_coefs[11:0]));
		t = longint'(t_raw);
		r.clamped = 1'b0;
		tn = 128 * c0 * kt + 256 * c1 * t;
		tq = tn / kt;
		if ((tn % kt) != 0 && tn < 0)
			tq = tq - 1;
		if (tq > 8388607) begin
			tq = 8388607;
			r.clamped = 1'b1;
		end else if (tq < -8388608) begin
			tq = -8388608;
			r.clamped = 1'b1;
		end
		r.temperature = tq[OUT_W-1:0];
		ktw = kt;
		kpw = kp;
		tw = t;
		p = longint'(p_raw);
		a3 = 64 * ktw * longint'($signed(sh_press_high[15:0]));
		a2 = 64 * (longint'($signed(sh_press_cross[15:0])) * ktw
			+ longint'($signed(sh_press_high[31:16])) * tw);
		a1 = 64 * (longint'($signed(sh_press_lin[19:0])) * ktw
			+ longint'($signed(sh_press_cross[31:16])) * tw);
		a0 = 64 * (longint'($signed(sh_press_lin[39:20])) * ktw
			+ longint'($signed(sh_press_cross[47:32])) * tw);
		s = ((a3 * p + a2 * kpw) * p + a1 * kpw * kpw) * p + a0 * kpw * kpw * kpw;
		den = ktw * kpw * kpw * kpw;
		if (s < 0) begin
			r.pressure = '0;
			r.clamped = 1'b1;
		end else begin
			q = s / den;
			if (q > 192'sd16777215) begin
				r.pressure = '1;
				r.clamped = 1'b1;
			end else begin
				r.pressure = q[OUT_W-1:0];
			end
		end
		return r;
	endfunction

	// leaves cfg_we high; the caller drops it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_TEMP_COEFS: sh_temp_coefs = val[23:0];
			CFG_PRESS_LIN: sh_press_lin = val[39:0];
			CFG_PRESS_CROSS: sh_press_cross = val[47:0];
			CFG_PRESS_HIGH: sh_press_high = val[31:0];
			CFG_TEMP_SCALE: sh_kt = val[SCALE_W-1:0];
			CFG_PRESS_SCALE: sh_kp = val[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_set(logic [23:0] tc, logic [39:0] pl, logic [47:0] pc,
			logic [31:0] ph, logic [SCALE_W-1:0] kt, logic [SCALE_W-1:0] kp);
		write_reg(CFG_TEMP_COEFS, CFG_W'(tc));
		write_reg(CFG_PRESS_LIN, CFG_W'(pl));
		write_reg(CFG_PRESS_CROSS, pc);
		write_reg(CFG_PRESS_HIGH, CFG_W'(ph));
		write_reg(CFG_TEMP_SCALE, CFG_W'(kt));
		write_reg(CFG_PRESS_SCALE, CFG_W'(kp));
		// spare indexes must not disturb anything
		write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
			CFG_W'({$urandom, $urandom}));
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// returns with the beat accepted at the current edge; in_valid left high
	task automatic send_beat(logic signed [RAW_W-1:0] t_raw, logic signed [RAW_W-1:0] p_raw,
			output result_t predicted);
		in_valid <= 1'b1;
		temp_code <= t_raw;
		press_code <= p_raw;
		do
			@(posedge clk);
		while (in_stall);
		predicted = compensate(t_raw, p_raw);
		pending.push_back(predicted);
		beats_in++;
	endtask

	function automatic logic signed [RAW_W-1:0] pick_raw(int realistic);
		case ($urandom_range(0, 7))
			0: return {1'b1, {(RAW_W-1){1'b0}}};
			1: return {1'b0, {(RAW_W-1){1'b1}}};
			2: return RAW_W'($urandom_range(0, 2) - 1);
			3, 4: return RAW_W'($urandom);
			default: begin
				if (realistic != 0)
					return RAW_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
				return RAW_W'($urandom);
			end
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_field_bits();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return CFG_W'({$urandom, $urandom} >> $urandom_range(8, 40));
			default: return CFG_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic logic [SCALE_W-1:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return SCALE_W'(1);
			3: return PRESS_SCALE_RST;
			4: return SCALE_W'($urandom_range(1, 4096));
			default: return SCALE_W'($urandom);
		endcase
	endfunction

	typedef struct {
		int set_id;
		logic signed [RAW_W-1:0] t_raw;
		logic signed [RAW_W-1:0] p_raw;
		bit typed;
		result_t want;
	} stim_row_t;

	localparam logic signed [RAW_W-1:0] RAW_MAX = 24'sh7FFFFF;
	localparam logic signed [RAW_W-1:0] RAW_MIN = -24'sh800000;
	localparam result_t ALL_ZERO = '{temperature: '0, pressure: '0, clamped: 1'b0};
	localparam result_t HOT_NEG = '{temperature: 24'h7FFFFF, pressure: '0, clamped: 1'b1};
	localparam result_t COLD_NEG = '{temperature: 24'h800000, pressure: '0, clamped: 1'b1};
	localparam result_t C0_NEG = '{temperature: 24'd262016, pressure: '0, clamped: 1'b1};
	localparam result_t C0_HIGH = '{temperature: 24'd262016, pressure: '1, clamped: 1'b1};

	stim_row_t directed[] = '{
		'{0, 24'sd0, 24'sd0, 1'b1, ALL_ZERO},
		'{0, RAW_MAX, RAW_MAX, 1'b1, ALL_ZERO},
		'{0, RAW_MIN, RAW_MIN, 1'b1, ALL_ZERO},
		'{0, RAW_MAX, RAW_MIN, 1'b1, ALL_ZERO},
		'{0, -24'sd1, 24'sd1, 1'b1, ALL_ZERO},
		// zero scales, full-scale c0/c1, most negative c00
		'{1, RAW_MAX, 24'sd0, 1'b1, HOT_NEG},
		'{1, RAW_MIN, 24'sd0, 1'b1, COLD_NEG},
		'{1, 24'sd0, 24'sd0, 1'b1, C0_NEG},
		'{1, RAW_MAX, RAW_MAX, 1'b0, ALL_ZERO},
		'{1, RAW_MIN, RAW_MIN, 1'b0, ALL_ZERO},
		'{1, 24'sd5, -24'sd7, 1'b0, ALL_ZERO},
		// largest c00/c10 with unit scales: pressure saturates high
		'{2, 24'sd0, RAW_MAX, 1'b1, C0_HIGH},
		'{2, 24'sd1, RAW_MIN, 1'b0, ALL_ZERO},
		'{2, RAW_MIN, 24'sd3, 1'b0, ALL_ZERO},
		// plausible sensor trim
		'{3, 24'sd0, 24'sd0, 1'b0, ALL_ZERO},
		'{3, 24'sd200000, -24'sd150000, 1'b0, ALL_ZERO},
		'{3, -24'sd300000, 24'sd400000, 1'b0, ALL_ZERO},
		'{3, 24'sd1234, 24'sd98765, 1'b0, ALL_ZERO}
	};

	// receiver: stall pattern switches between randomly chosen modes, checks each result beat
	int stall_mode = 0;
	int stall_tick = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending.size() == 0) begin
					$display("%0t: result beat with nothing expected: t=%h p=%h c=%b",
						$time, temperature_out, pressure_out, clamped);
					errors++;
				end else begin
					result_t w;
					w = pending.pop_front();
					beats_out++;
					if (w.clamped)
						clamp_seen++;
					if (w.pressure != '0 && w.pressure != '1)
						press_mid++;
					if (temperature_out !== w.temperature) begin
						$display("%0t: temperature_out expected %h actual %h", $time,
							w.temperature, temperature_out);
						errors++;
					end
					if (pressure_out !== w.pressure) begin
						$display("%0t: pressure_out expected %h actual %h", $time,
							w.pressure, pressure_out);
						errors++;
					end
					if (clamped !== w.clamped) begin
						$display("%0t: clamped expected %b actual %b", $time,
							w.clamped, clamped);
						errors++;
					end
				end
			end
			stall_tick++;
			if (stall_tick % 48 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= (stall_tick % 16) < 11;
				default: out_stall <= ($urandom_range(0, 1) != 0);
			endcase
		end
	end

	initial begin
		#4ms;
		$display("[barometer_compensation] ERROR");
		$finish;
	end

	initial begin
		result_t got;
		int cur_set;
		int burst;
		int realistic;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_set = 0;
		foreach (directed[i]) begin
			if (directed[i].set_id != cur_set) begin
				drain();
				cur_set = directed[i].set_id;
				case (cur_set)
					1: apply_set(24'h7FF7FF, 40'h8000000000, '0, '0, '0, '0);
					2: apply_set(24'h7FF7FF, 40'h7FFFF7FFFF, '0, '0, '0, '0);
					default: apply_set(24'h0C8EFC, 40'h13880F3CB0, 48'hF83004B0E0C0,
						32'h0064FED4, SCALE_W'(524288), SCALE_W'(1572864));
				endcase
			end
			send_beat(directed[i].t_raw, directed[i].p_raw, got);
			if (directed[i].typed && got != directed[i].want) begin
				$display("%0t: directed row %0d expected %h actual prediction %h", $time,
					i, directed[i].want, got);
				errors++;
			end
			if ($urandom_range(0, 2) == 0) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			realistic = (ph % 3 == 0);
			if (ph == 1)
				apply_set('1, '1, '1, '1, '1, '1);
			else if (realistic != 0)
				apply_set({12'(200 + $urandom_range(0, 40)), 12'hEFC},
					{20'(80000 + $urandom_range(0, 20000)), 20'hF3CB0},
					{16'hF830, 16'(1200 + $urandom_range(0, 300)), 16'hE0C0},
					{16'(100 + $urandom_range(0, 50)), 16'hFED4},
					SCALE_W'(524288), SCALE_W'(1572864));
			else
				apply_set(24'(pick_field_bits()), 40'(pick_field_bits()), pick_field_bits(),
					32'(pick_field_bits()), pick_scale(), pick_scale());
			burst = $urandom_range(1, 30);
			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				send_beat(pick_raw(realistic), pick_raw(realistic), got);
				burst--;
				if (burst <= 0) begin
					burst = $urandom_range(1, 30);
					if ($urandom_range(0, 3) != 0) begin
						in_valid <= 1'b0;
						repeat ($urandom_range(1, 12)) @(posedge clk);
					end
				end
			end
		end

		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Sent %0d raw pairs over %0d config phases; %0d results checked.",
			beats_in, RAND_PHASES + 4, beats_out);
		$display("%0d results saturated, %0d with in-range pressure.", clamp_seen, press_mid);
		if (errors == 0)
			$display("[barometer_compensation] OK");
		else
			$display("[barometer_compensation] ERROR");
		$finish;
	end

endmodule

// File: files.f
hdl/baro_pkg.sv
hdl/baro_mac.sv
hdl/baro_div.sv
hdl/baro_front.sv
hdl/baro_poly.sv
hdl/barometer_compensation.sv
dv/testbench.sv
